@@ hw/rtl/kmst_pkg.sv @@
// kmst_pkg: shared widths and types for the Kruskal MST weight core.
// No dependencies; imported by kruskal_mst_weight_core.
`timescale 1ns / 1ps

package kmst_pkg;

   localparam int VIDX_BITS    = 6;   // endpoint field width
   localparam int WIN_BITS     = 16;  // weight field width on the port
   localparam int VCOUNT_BITS  = 7;
   localparam int TOTAL_BITS   = 22;
   localparam int TAKEN_BITS   = 6;
   localparam logic [VCOUNT_BITS-1:0] VCOUNT_RESET = 7'd64;

   typedef logic [VIDX_BITS-1:0]   vidx_type;
   typedef logic [WIN_BITS-1:0]    win_type;
   typedef logic [VCOUNT_BITS-1:0] vcount_type;
   typedef logic [TOTAL_BITS-1:0]  total_type;
   typedef logic [TAKEN_BITS-1:0]  taken_type;

endpackage

@@ hw/rtl/kruskal_mst_weight_core.sv @@
// kruskal_mst_weight_core: loads edges, then Kruskal MST weight by weight-pass scans
// and union-find. Depends on kmst_pkg, kmst_edge_mem and kmst_parent_mem.
//
//  channel | ports                                      | dir | handshake
//  req     | req_edge_from/to/weight, req_last_edge     | in  | req_valid / req_stall
//  rsp     | rsp_total_weight, rsp_edges_taken,
//          | rsp_input_dropped                          | out | rsp_valid / rsp_stall
//  csr     | csr_wr_data (vertex_count)                 | in  | csr_wr_en
//
// Loading: one edge item per cycle. After the last item the core is busy: a parent
// table init over all VERTICES_MAX entries, then one scan of the store per distinct
// weight present, plus one for weight zero if absent (a read and an evaluate state
// per edge, plus a read and a check state per find step and a link state for each
// edge of the current weight); the scans stop early once the tree is complete.
// Synchronous active-high reset clears control; memories need no clearing.
// The result waits in an output register; a non-last item may be loaded meanwhile.
`timescale 1ns / 1ps

module kruskal_mst_weight_core #(
   parameter int VERTICES_MAX = 64,
   parameter int EDGES_MAX    = 1024,
   parameter int WEIGHT_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  kmst_pkg::vidx_type    req_edge_from,
   input  kmst_pkg::vidx_type    req_edge_to,
   input  kmst_pkg::win_type     req_edge_weight,
   input  logic                  req_last_edge,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output kmst_pkg::total_type   rsp_total_weight,
   output kmst_pkg::taken_type   rsp_edges_taken,
   output logic                  rsp_input_dropped,
   input  logic                  csr_wr_en,
   input  kmst_pkg::vcount_type  csr_wr_data
);

   import kmst_pkg::*;

   localparam int VW = (VERTICES_MAX > 1) ? $clog2(VERTICES_MAX) : 1;
   localparam int NW = $clog2(VERTICES_MAX + 1);
   localparam int AW = (EDGES_MAX > 1) ? $clog2(EDGES_MAX) : 1;
   localparam int FW = $clog2(EDGES_MAX + 1);
   localparam int WB = WEIGHT_BITS;
   localparam int DW = 2 * VIDX_BITS + WB;
   localparam int SW = (WB + 1 > TOTAL_BITS + 1) ? WB + 1 : TOTAL_BITS + 1;
   localparam total_type TOTAL_MAX = {TOTAL_BITS{1'b1}};

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_INIT  = 4'd1;
   localparam logic [3:0] S_RD    = 4'd2;
   localparam logic [3:0] S_EVAL  = 4'd3;
   localparam logic [3:0] S_FA_RD = 4'd4;
   localparam logic [3:0] S_FA_CK = 4'd5;
   localparam logic [3:0] S_FB_RD = 4'd6;
   localparam logic [3:0] S_FB_CK = 4'd7;
   localparam logic [3:0] S_LINK  = 4'd8;
   localparam logic [3:0] S_DONE  = 4'd9;

   logic [3:0]    state_ff, state_in;
   vcount_type    vcount_ff, vcount_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic          drop_ff, drop_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [VW-1:0] init_ff, init_in;
   logic [WB-1:0] cur_w_ff, cur_w_in;
   logic [WB-1:0] nxt_w_ff, nxt_w_in;
   logic          found_ff, found_in;
   logic [VW-1:0] x_ff, x_in;
   logic [VW-1:0] ra_ff, ra_in;
   logic [VW-1:0] rb_ff, rb_in;
   logic [VW-1:0] to_ff, to_in;
   logic [WB-1:0] ew_ff, ew_in;
   logic [NW-1:0] taken_ff, taken_in;
   total_type     total_ff, total_in;
   logic          rsp_valid_ff, rsp_valid_in;
   total_type     rsp_total_ff, rsp_total_in;
   taken_type     rsp_taken_ff, rsp_taken_in;
   logic          rsp_drop_ff, rsp_drop_in;

   logic [NW-1:0] n_eff;
   logic          req_fire, req_ok, rsp_free;
   logic [DW-1:0] edge_wdata, edge_q;
   vidx_type      q_from, q_to;
   logic [WB-1:0] q_w;
   logic          par_we;
   logic [VW-1:0] par_waddr, par_wdata, par_raddr, par_q;
   logic [SW-1:0] sum_w;
   logic [NW-1:0] taken_nx;
   logic          last_in_pass;

   kmst_edge_mem #(.DEPTH(EDGES_MAX), .AW(AW), .DW(DW)) u_edges (
      .clock   (clock),
      .wr_en   (req_fire && req_ok),
      .wr_addr (AW'(fill_ff)),
      .wr_data (edge_wdata),
      .rd_addr (idx_ff),
      .rd_data (edge_q)
   );

   kmst_parent_mem #(.DEPTH(VERTICES_MAX), .VW(VW)) u_parent (
      .clock   (clock),
      .wr_en   (par_we),
      .wr_addr (par_waddr),
      .wr_data (par_wdata),
      .rd_addr (par_raddr),
      .rd_data (par_q)
   );

   assign n_eff = (32'(vcount_ff) > VERTICES_MAX) ? NW'(VERTICES_MAX) : NW'(vcount_ff);
   assign req_stall = (state_ff != S_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign req_ok    = (32'(req_edge_from) < 32'(n_eff)) && (32'(req_edge_to) < 32'(n_eff))
                      && (32'(fill_ff) < EDGES_MAX);
   assign edge_wdata = {req_edge_from, req_edge_to, WB'(req_edge_weight)};
   assign q_from = edge_q[DW-1 -: VIDX_BITS];
   assign q_to   = edge_q[WB +: VIDX_BITS];
   assign q_w    = edge_q[WB-1:0];
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign par_raddr = x_ff;
   assign sum_w    = SW'(total_ff) + SW'(ew_ff);
   assign taken_nx = taken_ff + NW'(1);
   assign last_in_pass = (FW'(idx_ff) + FW'(1)) == fill_ff;

   always_comb begin
      state_in     = state_ff;
      vcount_in    = csr_wr_en ? csr_wr_data : vcount_ff;
      fill_in      = fill_ff;
      drop_in      = drop_ff;
      idx_in       = idx_ff;
      init_in      = init_ff;
      cur_w_in     = cur_w_ff;
      nxt_w_in     = nxt_w_ff;
      found_in     = found_ff;
      x_in         = x_ff;
      ra_in        = ra_ff;
      rb_in        = rb_ff;
      to_in        = to_ff;
      ew_in        = ew_ff;
      taken_in     = taken_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_total_in = rsp_total_ff;
      rsp_taken_in = rsp_taken_ff;
      rsp_drop_in  = rsp_drop_ff;
      par_we       = 1'b0;
      par_waddr    = init_ff;
      par_wdata    = init_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_ok) begin
                  fill_in = fill_ff + FW'(1);
               end else begin
                  drop_in = 1'b1;
               end
               if (req_last_edge) begin
                  init_in  = '0;
                  state_in = S_INIT;
               end
            end
         end
         S_INIT: begin
            par_we  = 1'b1;
            init_in = init_ff + VW'(1);
            if (32'(init_ff) == VERTICES_MAX - 1) begin
               idx_in   = '0;
               cur_w_in = '0;
               found_in = 1'b0;
               taken_in = '0;
               total_in = '0;
               state_in = (fill_ff == '0 || n_eff <= NW'(1)) ? S_DONE : S_RD;
            end
         end
         S_RD: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (q_w > cur_w_ff && (!found_ff || q_w < nxt_w_ff)) begin
               nxt_w_in = q_w;
               found_in = 1'b1;
            end
            if (q_w == cur_w_ff && 32'(q_from) < 32'(n_eff) && 32'(q_to) < 32'(n_eff)) begin
               x_in     = VW'(q_from);
               to_in    = VW'(q_to);
               ew_in    = q_w;
               state_in = S_FA_RD;
            end else if (!last_in_pass) begin
               idx_in   = idx_ff + AW'(1);
               state_in = S_RD;
            end else if (found_ff || (q_w > cur_w_ff)) begin
               // next distinct weight, including the one seen on this very edge
               cur_w_in = (q_w > cur_w_ff && (!found_ff || q_w < nxt_w_ff)) ? q_w : nxt_w_ff;
               found_in = 1'b0;
               idx_in   = '0;
               state_in = S_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_FA_RD: state_in = S_FA_CK;
         S_FA_CK: begin
            if (par_q == x_ff) begin
               ra_in    = x_ff;
               x_in     = to_ff;
               state_in = S_FB_RD;
            end else begin
               x_in     = par_q;
               state_in = S_FA_RD;
            end
         end
         S_FB_RD: state_in = S_FB_CK;
         S_FB_CK: begin
            if (par_q == x_ff) begin
               rb_in    = x_ff;
               state_in = S_LINK;
            end else begin
               x_in     = par_q;
               state_in = S_FB_RD;
            end
         end
         S_LINK: begin
            if (ra_ff != rb_ff) begin
               par_we    = 1'b1;
               par_waddr = (ra_ff < rb_ff) ? rb_ff : ra_ff;
               par_wdata = (ra_ff < rb_ff) ? ra_ff : rb_ff;
               taken_in  = taken_nx;
               total_in  = (sum_w > SW'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_BITS'(sum_w);
            end
            priority if (ra_ff != rb_ff && 32'(taken_nx) >= 32'(n_eff) - 1) begin
               state_in = S_DONE;
            end else if (!last_in_pass) begin
               idx_in   = idx_ff + AW'(1);
               state_in = S_RD;
            end else if (found_ff) begin
               cur_w_in = nxt_w_ff;
               found_in = 1'b0;
               idx_in   = '0;
               state_in = S_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_total_in = total_ff;
               rsp_taken_in = TAKEN_BITS'(taken_ff);
               rsp_drop_in  = drop_ff;
               fill_in      = '0;
               drop_in      = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         vcount_ff    <= VCOUNT_RESET;
         fill_ff      <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vcount_ff    <= vcount_in;
         fill_ff      <= fill_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      init_ff      <= init_in;
      cur_w_ff     <= cur_w_in;
      nxt_w_ff     <= nxt_w_in;
      found_ff     <= found_in;
      x_ff         <= x_in;
      ra_ff        <= ra_in;
      rb_ff        <= rb_in;
      to_ff        <= to_in;
      ew_ff        <= ew_in;
      taken_ff     <= taken_in;
      total_ff     <= total_in;
      rsp_total_ff <= rsp_total_in;
      rsp_taken_ff <= rsp_taken_in;
      rsp_drop_ff  <= rsp_drop_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_total_weight  = rsp_total_ff;
   assign rsp_edges_taken   = rsp_taken_ff;
   assign rsp_input_dropped = rsp_drop_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= EDGES_MAX)
      else $error("edge fill beyond store depth");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("result raised outside done state");

   a_fill_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_free) |=> (fill_ff == '0 && !drop_ff))
      else $error("store not cleared after result");

   a_taken_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LINK) |-> 32'(taken_ff) + 1 < 32'(n_eff))
      else $error("link attempted after tree complete");

endmodule

@@ hw/rtl/kmst_edge_mem.sv @@
// kmst_edge_mem: edge store, one write and one registered read port.
// No dependencies; used by kruskal_mst_weight_core.
`timescale 1ns / 1ps

module kmst_edge_mem #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10,
   parameter int DW    = 28
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ hw/rtl/kmst_parent_mem.sv @@
// kmst_parent_mem: union-find parent table, one write and one registered read port.
// No dependencies; used by kruskal_mst_weight_core.
`timescale 1ns / 1ps

module kmst_parent_mem #(
   parameter int DEPTH = 64,
   parameter int VW    = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [VW-1:0] wr_addr,
   input  logic [VW-1:0] wr_data,
   input  logic [VW-1:0] rd_addr,
   output logic [VW-1:0] rd_data
);

   logic [VW-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
